// ===== rtl/chord_pairwise_dissonance_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chord dissonance scorer
// Each macro checks on the rising edge of clk and is held off during reset.
// ----------------------------------------------------------------------------
`ifndef CHORD_PAIRWISE_DISSONANCE_MACROS_SVH
`define CHORD_PAIRWISE_DISSONANCE_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define CPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpd assertion failed");

// Consequent must hold in the cycle after the antecedent
`define CPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpd assertion failed");

`else

`define CPD_ASSERT_IMPL(label, ante, cons)
`define CPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, widths and the interval rating for the chord dissonance scorer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Default and upper bound of the note capacity
    localparam int MAX_NOTES_DEF = 16;
    localparam int MAX_NOTES_LIM = 32;

    // Field widths
    localparam int NOTE_W    = 7;
    localparam int THR_W     = 12;
    localparam int SCORE_W   = 12;
    localparam int OUT_CNT_W = 5;
    localparam int FRAC_W    = 8;

    // Internal widths, sized for the largest capacity
    localparam int CNT_W   = $clog2(MAX_NOTES_LIM + 1);
    localparam int PAIRS_LIM = MAX_NOTES_LIM * (MAX_NOTES_LIM - 1) / 2;
    localparam int PAIR_W  = $clog2(PAIRS_LIM + 1);
    localparam int RATING_MAX = 9;
    localparam int SUM_W   = $clog2(RATING_MAX * PAIRS_LIM + 1);
    localparam int DIVD_W  = SUM_W + FRAC_W;

    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1280);
    localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(RATING_MAX * 256);

    // One input beat
    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              last_note;
    } note_beat_t;

    // One result beat
    typedef struct packed {
        logic [SCORE_W-1:0]   dissonance_score;
        logic                 consonant;
        logic [OUT_CNT_W-1:0] notes_counted;
        logic                 overflowed;
    } result_beat_t;

    // Token that walks the row of cells
    typedef struct packed {
        logic              valid;
        logic [NOTE_W-1:0] note;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
    } cpd_token_t;

    // Dissonance rating in tenths for a semitone distance, folded mod 12
    function automatic logic [3:0] interval_rating(input logic [NOTE_W-1:0] span);
        logic [12:0]       prod;
        logic [3:0]        octaves;
        logic [NOTE_W-1:0] pc;
        logic [3:0]        rating;
        // floor(span / 12) as span * 43 >> 9, exact for span below 128
        prod    = 13'(span) * 13'd43;
        octaves = prod[12:9];
        pc      = span - NOTE_W'(octaves) * NOTE_W'(12);
        unique case (pc[3:0])
            4'd0:    rating = 4'd0;
            4'd1:    rating = 4'd8;
            4'd2:    rating = 4'd4;
            4'd3:    rating = 4'd5;
            4'd4:    rating = 4'd3;
            4'd5:    rating = 4'd2;
            4'd6:    rating = 4'd9;
            4'd7:    rating = 4'd1;
            4'd8:    rating = 4'd4;
            4'd9:    rating = 4'd3;
            4'd10:   rating = 4'd5;
            4'd11:   rating = 4'd4;
            default: rating = 4'd0;
        endcase
        return rating;
    endfunction

endpackage

// ===== rtl/cpd_cell.sv =====
// ----------------------------------------------------------------------------
// cpd_cell
// One slot of the note row: holds one stored note, rates a passing note
// against it and hands the token on to the next slot.
// ----------------------------------------------------------------------------
module cpd_cell
    import cpd_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cpd_token_t tok_in,
    output cpd_token_t tok_out
);

    logic [NOTE_W-1:0] stored_reg;
    logic              tok_valid_reg;
    cpd_token_t        tok_pay_reg;
    logic [NOTE_W-1:0] span;
    logic              occupied;
    logic [SUM_W-1:0]  sum_next;

    // Rate the passing note against this slot when the slot is in use
    assign occupied = CNT_W'(IDX) < tok_in.count;
    assign span     = (tok_in.note > stored_reg) ? (tok_in.note - stored_reg)
                                                 : (stored_reg - tok_in.note);
    assign sum_next = occupied ? (tok_in.sum + SUM_W'(interval_rating(span))) : tok_in.sum;

    // Advance token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    // Advance token payload, store the note in the first free slot
    always_ff @(posedge clk)
    begin
        tok_pay_reg.valid <= 1'b0;
        tok_pay_reg.note  <= tok_in.note;
        tok_pay_reg.count <= tok_in.count;
        tok_pay_reg.sum   <= sum_next;
        if (tok_in.valid && (tok_in.count == CNT_W'(IDX)))
        begin
            stored_reg <= tok_in.note;
        end
    end

    always_comb
    begin
        tok_out       = tok_pay_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

// ===== rtl/cpd_divider.sv =====
// ----------------------------------------------------------------------------
// cpd_divider
// Restoring divider, one quotient bit per cycle, for the mean pair rating.
// ----------------------------------------------------------------------------
module cpd_divider
    import cpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [PAIR_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PAIR_W-1:0] rem_reg;
    logic [PAIR_W-1:0] dvs_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [PAIR_W:0]   trial;
    logic              fits;

    // Shift the next dividend bit into the partial remainder and test it
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Count steps and flag the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DIVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Load operands, then subtract and shift one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? PAIR_W'(trial - {1'b0, dvs_reg}) : trial[PAIR_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/chord_pairwise_dissonance.sv =====
// ----------------------------------------------------------------------------
// chord_pairwise_dissonance
// Scores a chord by the mean dissonance of all its note pairs.
// ----------------------------------------------------------------------------
// Notes of one chord arrive one beat at a time. For each stored note, a
// token carrying the new note walks the row of MAX_NOTES cells, one cell
// per cycle, picking up the rating against every stored note, and the last
// cell returns the updated sum; no new note is taken during the walk. A note
// beyond capacity is dropped and only sets the overflow flag. On the note
// marked last, a restoring divider works through each bit of the rating sum
// with 8 fraction bits, and the quotient is then loaded into the result
// register. The result register lets the next chord start while a score
// waits to be taken; a second score waits in the divider until the first
// one leaves.
module chord_pairwise_dissonance
    import cpd_pkg::*;
#(
    parameter int MAX_NOTES = MAX_NOTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             note_valid,
    output logic             note_stall,
    input  note_beat_t       chord_note,
    output logic             result_valid,
    input  logic             result_stall,
    output result_beat_t     result,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata
);

`include "chord_pairwise_dissonance_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DIV,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  note_total_reg;
    logic [PAIR_W-1:0] pair_total_reg;
    logic [SUM_W-1:0]  rating_sum_reg;
    logic              dropped_reg;
    logic              last_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              result_valid_reg;
    result_beat_t      result_reg;

    cpd_token_t        tok [0:MAX_NOTES];
    logic              note_acc;
    logic              has_room;
    logic              tok_done;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic              div_done;
    logic [DIVD_W-1:0] div_quotient;
    logic              slot_free;
    logic              load_result;
    result_beat_t      result_next;

    // Input handshake
    assign note_stall = (state_reg != S_IDLE);
    assign note_acc   = note_valid && !note_stall;
    assign has_room   = note_total_reg < CNT_W'(MAX_NOTES);

    // Launch a token into the first cell
    always_comb
    begin
        tok[0].valid = note_acc && has_room;
        tok[0].note  = chord_note.note;
        tok[0].count = note_total_reg;
        tok[0].sum   = rating_sum_reg;
    end

    // Row of note cells
    for (genvar g = 0; g < MAX_NOTES; g++)
    begin : g_cell
        cpd_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tok_done = (state_reg == S_RUN) && tok[MAX_NOTES].valid;

    // Start the mean on the last note, after its walk or at once if dropped
    assign div_start = (tok_done && last_reg)
                    || (note_acc && !has_room && chord_note.last_note);
    assign div_dividend = (state_reg == S_RUN) ? {tok[MAX_NOTES].sum, FRAC_W'(0)}
                                               : {rating_sum_reg, FRAC_W'(0)};

    cpd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pair_total_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Build the result beat; no pairs gives a score of zero
    always_comb
    begin
        result_next.dissonance_score = (pair_total_reg == '0) ? '0 : div_quotient[SCORE_W-1:0];
        result_next.consonant        = result_next.dissonance_score < thr_reg;
        result_next.notes_counted    = note_total_reg[OUT_CNT_W-1:0];
        result_next.overflowed       = dropped_reg;
    end

    assign slot_free   = !result_valid_reg || !result_stall;
    assign load_result = slot_free && (((state_reg == S_DIV) && div_done)
                                       || (state_reg == S_DONE));

    // Sequence the chord, hold chord state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            note_total_reg   <= '0;
            pair_total_reg   <= '0;
            rating_sum_reg   <= '0;
            dropped_reg      <= 1'b0;
            last_reg         <= 1'b0;
            thr_reg          <= THR_RESET;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end

            // Drop the result beat once taken, unless a new one replaces it
            if (result_valid_reg && !result_stall && !load_result)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (note_acc)
                    begin
                        if (has_room)
                        begin
                            note_total_reg <= note_total_reg + 1'b1;
                            pair_total_reg <= pair_total_reg + PAIR_W'(note_total_reg);
                            last_reg       <= chord_note.last_note;
                            state_reg      <= S_RUN;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                            if (chord_note.last_note)
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                    end
                end
                S_RUN:
                begin
                    if (tok_done)
                    begin
                        rating_sum_reg <= tok[MAX_NOTES].sum;
                        state_reg      <= last_reg ? S_DIV : S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_done && !slot_free)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Load the result and clear the chord
            if (load_result)
            begin
                result_reg       <= result_next;
                result_valid_reg <= 1'b1;
                note_total_reg   <= '0;
                pair_total_reg   <= '0;
                rating_sum_reg   <= '0;
                dropped_reg      <= 1'b0;
                state_reg        <= S_IDLE;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `CPD_ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == S_DIV)
    `CPD_ASSERT_IMPL(a_score_range, result_valid, result.dissonance_score <= SCORE_MAX)
    `CPD_ASSERT_NEXT(a_chord_cleared, load_result, note_total_reg == '0 && pair_total_reg == '0)
    `CPD_ASSERT_IMPL(a_no_pairs_below_two, note_total_reg < CNT_W'(2), pair_total_reg == '0)

endmodule
